// ----- design/assert_macros.svh -----
// assert_macros.svh: assertion macros for the RTL file that checks itself, ascii85_decoder_top.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// Check that a condition implies another one in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies another one in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/a85_pkg.sv -----
// a85_pkg: types, character codes, status codes and base-85 weights of the decoder.
// Depends on nothing; used by a85_decode, a85_grp_fifo, a85_serial and ascii85_decoder_top.
`timescale 1ns / 1ps
`default_nettype none

package a85_pkg;

  // result status codes
  localparam logic [1:0] ST_DATA       = 2'd0;
  localparam logic [1:0] ST_Z_IN_GROUP = 2'd1;
  localparam logic [1:0] ST_BAD_CHAR   = 2'd2;
  localparam logic [1:0] ST_SHORT_END  = 2'd3;

  // item kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // character codes
  localparam logic [7:0] CH_FIRST = 8'd33;   // '!', digit value 0
  localparam logic [7:0] CH_LAST  = 8'd117;  // 'u', digit value 84
  localparam logic [7:0] CH_Z     = 8'd122;  // 'z', four zero bytes
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;

  // group geometry
  localparam logic [2:0] LAST_DIGIT  = 3'd4;  // index of the fifth digit
  localparam logic [2:0] GROUP_BYTES = 3'd4;

  typedef logic [31:0] a85_word_t;
  typedef logic [2:0]  a85_count_t;

  // one queued group: word to send, bytes to send from the top, status
  typedef struct packed {
    a85_word_t  word;
    a85_count_t nbytes;
    logic [1:0] status;
  } a85_group_t;

  // weight of the digit at position idx, most significant digit first
  function automatic logic [26:0] pow85(input a85_count_t idx);
    logic [26:0] w;
    case (idx)
      3'd0:    w = 27'd52200625;
      3'd1:    w = 27'd614125;
      3'd2:    w = 27'd7225;
      3'd3:    w = 27'd85;
      default: w = 27'd1;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- design/a85_in_if.sv -----
// a85_in_if: character channel of the decoder, valid/ready with kind and char_code.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface a85_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_code;

  modport source (output valid, kind, char_code, input ready);
  modport sink   (input valid, kind, char_code, output ready);
endinterface

`default_nettype wire

// ----- design/a85_out_if.sv -----
// a85_out_if: byte channel of the decoder, valid/ready with data_byte, status and last.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface a85_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [1:0] status;
  logic       last;

  modport source (output valid, data_byte, status, last, input ready);
  modport sink   (input valid, data_byte, status, last, output ready);
endinterface

`default_nettype wire

// ----- design/a85_decode.sv -----
// a85_decode: group accumulator; turns accepted characters and end marks into queued groups.
// Depends on a85_pkg.
`timescale 1ns / 1ps
`default_nettype none

module a85_decode (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire logic                kind,
  input  wire logic [7:0]          char_code,
  output logic                     push,
  output a85_pkg::a85_group_t      group
);

  a85_pkg::a85_word_t  group_value, group_value_next;
  a85_pkg::a85_count_t digit_count, digit_count_next;

  logic [6:0]  digit_wide;
  logic [31:0] product;
  logic [31:0] digit_sum;
  logic [31:0] end_sum;

  assign digit_wide = 7'(char_code - a85_pkg::CH_FIRST);
  assign product    = 32'(digit_wide) * 32'(a85_pkg::pow85(digit_count));
  assign digit_sum  = group_value + product;
  assign end_sum    = group_value + 32'(a85_pkg::pow85(digit_count - 3'd1));

  always_comb begin
    push             = 1'b0;
    group            = '0;
    group_value_next = group_value;
    digit_count_next = digit_count;
    if (accept) begin
      if (kind == a85_pkg::KIND_END) begin
        if (digit_count == 3'd1) begin
          push             = 1'b1;
          group.nbytes     = 3'd1;
          group.status     = a85_pkg::ST_SHORT_END;
          group_value_next = '0;
          digit_count_next = '0;
        end else if (digit_count != 3'd0) begin
          push             = 1'b1;
          group.word       = end_sum;
          group.nbytes     = digit_count - 3'd1;
          group.status     = a85_pkg::ST_DATA;
          group_value_next = '0;
          digit_count_next = '0;
        end
      end else if (char_code == a85_pkg::CH_Z) begin
        push = 1'b1;
        if (digit_count != 3'd0) begin
          group.nbytes     = 3'd1;
          group.status     = a85_pkg::ST_Z_IN_GROUP;
          group_value_next = '0;
          digit_count_next = '0;
        end else begin
          group.nbytes = a85_pkg::GROUP_BYTES;
          group.status = a85_pkg::ST_DATA;
        end
      end else if (char_code inside {a85_pkg::CH_NUL, a85_pkg::CH_BS, a85_pkg::CH_TAB,
                                     a85_pkg::CH_LF, a85_pkg::CH_FF, a85_pkg::CH_CR}) begin
        // whitespace and control fillers: drop
      end else if (char_code < a85_pkg::CH_FIRST || char_code > a85_pkg::CH_LAST) begin
        push             = 1'b1;
        group.nbytes     = 3'd1;
        group.status     = a85_pkg::ST_BAD_CHAR;
        group_value_next = '0;
        digit_count_next = '0;
      end else if (digit_count == a85_pkg::LAST_DIGIT) begin
        push             = 1'b1;
        group.word       = digit_sum;
        group.nbytes     = a85_pkg::GROUP_BYTES;
        group.status     = a85_pkg::ST_DATA;
        group_value_next = '0;
        digit_count_next = '0;
      end else begin
        group_value_next = digit_sum;
        digit_count_next = digit_count + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_value <= '0;
      digit_count <= '0;
    end else begin
      group_value <= group_value_next;
      digit_count <= digit_count_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/a85_grp_fifo.sv -----
// a85_grp_fifo: two-entry queue of decoded groups between accumulator and byte serializer.
// Depends on a85_pkg.
`timescale 1ns / 1ps
`default_nettype none

module a85_grp_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire a85_pkg::a85_group_t din,
  input  wire logic                pop,
  output logic                     full,
  output logic                     valid,
  output a85_pkg::a85_group_t      dout
);

  a85_pkg::a85_group_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full  = (fill == 2'd2);
  assign valid = (fill != 2'd0);
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/a85_serial.sv -----
// a85_serial: output register that sends a queued group one byte per transfer, top byte first.
// Depends on a85_pkg and a85_out_if.
`timescale 1ns / 1ps
`default_nettype none

module a85_serial (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  input  wire a85_pkg::a85_group_t q_group,
  output logic                     pop,
  a85_out_if.source                dst
);

  logic                busy;
  a85_pkg::a85_word_t  word;
  a85_pkg::a85_count_t remaining;
  logic [1:0]          status;
  logic                done;

  assign dst.valid     = busy;
  assign dst.data_byte = word[31:24];
  assign dst.status    = status;
  assign dst.last      = (remaining == 3'd1);

  assign done = busy && dst.ready && (remaining == 3'd1);
  assign pop  = q_valid && (!busy || done);

  always_ff @(posedge clk) begin
    if (pop) begin
      word      <= q_group.word;
      remaining <= q_group.nbytes;
      status    <= q_group.status;
    end else if (busy && dst.ready) begin
      word      <= {word[23:0], 8'h00};
      remaining <= remaining - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (pop) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- design/ascii85_decoder_top.sv -----
// ascii85_decoder_top: base-85 text decoder, characters in and bytes out.
// Depends on a85_pkg, a85_in_if, a85_out_if, a85_decode, a85_grp_fifo, a85_serial, assert_macros.svh.
//
//   channel   dir  payload                        moves per transfer
//   char_in   in   kind, char_code                one character or end mark
//   byte_out  out  data_byte, status, last        one decoded byte or error
//
// Flow: a character transfer is taken every cycle while the group queue has room;
//   the accumulator updates in the cycle of the transfer and a finished group enters
//   the queue at that edge. Bytes leave at one per cycle while byte_out.ready is high;
//   a queued group is loaded into the output register when it is idle or sends its last byte.
// Reset: rst clears the group accumulator, the queue and the output register's busy flag.
// Stalls: byte_out.ready low holds the current byte; the two-entry queue then fills
//   and char_in.ready drops until a whole group has gone out.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ascii85_decoder_top (
  input  wire logic clk,
  input  wire logic rst,
  a85_in_if.sink    char_in,
  a85_out_if.source byte_out
);

  logic                accept;
  logic                push;
  a85_pkg::a85_group_t group;
  logic                q_full;
  logic                q_valid;
  a85_pkg::a85_group_t q_group;
  logic                pop;

  // Take a character whenever the queue can hold whatever it may produce.
  assign char_in.ready = !q_full;
  assign accept        = char_in.valid && char_in.ready;

  // Accumulate digits; emit a group on a fifth digit, a 'z', an end mark after a partial group or an error.
  a85_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .kind      (char_in.kind),
    .char_code (char_in.char_code),
    .push      (push),
    .group     (group)
  );

  // Buffer groups so the input side keeps moving while bytes drain.
  a85_grp_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (group),
    .pop   (pop),
    .full  (q_full),
    .valid (q_valid),
    .dout  (q_group)
  );

  // Send each group top byte first, marking the final byte of the item.
  a85_serial u_serial (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_group (q_group),
    .pop     (pop),
    .dst     (byte_out)
  );

  // Error results carry a zero byte and close their item.
  `ASSERT_SAME(a_err_last, clk, rst, byte_out.valid && byte_out.status != a85_pkg::ST_DATA, byte_out.last && byte_out.data_byte == 8'h00)
  // A group enters the queue only on an accepted character transfer.
  `ASSERT_SAME(a_push_on_accept, clk, rst, push, char_in.valid && char_in.ready)
  // A queued group never waits behind an idle output register.
  `ASSERT_NEXT(a_load_when_idle, clk, rst, q_valid && !byte_out.valid, byte_out.valid)
  // A full queue never takes another group.
  `ASSERT_ALWAYS(a_no_push_full, clk, rst, !(push && q_full))

endmodule

`default_nettype wire
